>>> sv/cam_pkg.sv
// Shared constants and types for the column argmin matcher.
package cam_pkg;

    // Field widths fixed by the stream format
    localparam int COST_W    = 32;
    localparam int ROW_W     = 10;
    localparam int COL_W     = 8;
    localparam int SRC_CNT_W = 10;
    localparam int TGT_CNT_W = 9;

    // Configuration port
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 1'd1;

    localparam logic [SRC_CNT_W-1:0] SOURCE_COUNT_RST = 10'd0;
    localparam logic [TGT_CNT_W-1:0] TARGET_COUNT_RST = 9'd1;

    // Parameter defaults
    localparam int DEF_MAX_TARGETS = 256;
    localparam int DEF_MAX_SOURCES = 1023;
    localparam int DEF_COST_WIDTH  = 32;

    // Stream word widths, padded to whole bytes
    localparam int S_TDATA_W = ((COST_W + ROW_W + COL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((COL_W + ROW_W + 7) / 8) * 8;

    // Control from the pipeline to the update stage
    typedef struct packed {
        logic commit;     // stage leaves this cycle, write back
        logic first_row;  // row 0: initialize the column
    } cam_ctrl_t;

endpackage

>>> sv/column_argmin_matcher_core.sv
// Top level of the column argmin matcher: stream ports, pipeline control, config.
//
// Usage: a cost matrix enters on the s_ stream one element per word, row-major,
// rows 0..source_count, columns 0..target_count-1. For every column the block
// tracks the lowest cost and the row that gave it (row 0 initializes, ties keep
// the earlier row). The element of the last row (row == source_count) makes
// one word on the m_ stream: the column and its winning source row, or
// has_source = 0 if the last row, meaning "no source", won. Elements of
// unused columns or rows beyond source_count are taken and dropped.
// Throughput: one word per cycle, sustained unless a stalled m_tready holds a reporting
// word, including back-to-back hits on the same column. A reporting word passes the update
// stage and then the output register. The rate comes from the single read-modify-write
// of the column memory: read at accept, compare and write back as the word leaves the
// update stage, with the previous write forwarded around the memory's read port.
// Reset (aresetn low, synchronous) clears the pipeline and output valid bits
// and sets source_count = 0, target_count = 1; column memory contents are
// undefined until row 0 of a column writes them. A stalled m_tready holds the
// output word; a reporting word then waits and s_tready drops. The user writes
// configuration through cfg_we/cfg_index/cfg_data while idle; not enforced by the block.
module column_argmin_matcher_core #(
    parameter int MAX_TARGETS = cam_pkg::DEF_MAX_TARGETS,
    parameter int MAX_SOURCES = cam_pkg::DEF_MAX_SOURCES,
    parameter int COST_WIDTH  = cam_pkg::DEF_COST_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [cam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cam_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cam_pkg::S_TDATA_W-1:0]     s_tdata,   // cost[31:0], row[41:32], column[49:42]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cam_pkg::M_TDATA_W-1:0]     m_tdata,   // target_index[7:0], source_index[17:8]
    output logic                              m_tuser    // has_source
);

    // Memory depth never exceeds what the column field can address
    localparam int DEPTH = (MAX_TARGETS < (1 << cam_pkg::COL_W)) ? MAX_TARGETS
                                                                 : (1 << cam_pkg::COL_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (COST_WIDTH < cam_pkg::COST_W) ? COST_WIDTH : cam_pkg::COST_W;

    // input word unpacking
    logic [cam_pkg::COST_W-1:0] in_cost;
    logic [cam_pkg::ROW_W-1:0]  in_row;
    logic [cam_pkg::COL_W-1:0]  in_col;

    assign in_cost = s_tdata[cam_pkg::COST_W-1:0];
    assign in_row  = s_tdata[cam_pkg::COST_W +: cam_pkg::ROW_W];
    assign in_col  = s_tdata[cam_pkg::COST_W + cam_pkg::ROW_W +: cam_pkg::COL_W];

    // configuration
    logic [cam_pkg::SRC_CNT_W-1:0] source_count_reg;
    logic [cam_pkg::TGT_CNT_W-1:0] target_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_count_reg <= cam_pkg::SOURCE_COUNT_RST;
            target_count_reg <= cam_pkg::TARGET_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                cam_pkg::REG_SOURCE_COUNT:
                    source_count_reg <= cfg_data[cam_pkg::SRC_CNT_W-1:0];
                cam_pkg::REG_TARGET_COUNT:
                    target_count_reg <= cfg_data[cam_pkg::TGT_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input filtering: drop unused columns and rows past the last
    logic in_accept;
    logic in_use;

    always_comb begin
        in_accept = s_tvalid && s_tready;
        in_use    = ({1'b0, in_col} < target_count_reg)
                 && (32'(in_col) < 32'(MAX_TARGETS))
                 && (in_row <= source_count_reg)
                 && (32'(in_row) <= 32'(MAX_SOURCES));
    end

    // update stage registers (memory read data lines up with these)
    logic                      s1_valid_reg;
    logic [cam_pkg::COL_W-1:0] s1_col_reg;
    logic [CW-1:0]             s1_cost_reg;
    logic [cam_pkg::ROW_W-1:0] s1_row_reg;
    logic                      s1_first_reg;
    logic                      s1_last_reg;

    // output register
    logic                      m_valid_reg;
    logic [cam_pkg::COL_W-1:0] m_target_reg;
    logic                      m_has_reg;
    logic [cam_pkg::ROW_W-1:0] m_src_reg;

    logic out_free;
    logic s1_advance;

    always_comb begin
        out_free   = !m_valid_reg || m_tready;
        // a stage word that reports nothing never waits on the output
        s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
        s_tready   = !s1_valid_reg || s1_advance;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= in_accept && in_use;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_col_reg   <= in_col;
            s1_cost_reg  <= in_cost[CW-1:0];
            s1_row_reg   <= in_row;
            s1_first_reg <= (in_row == '0);
            s1_last_reg  <= (in_row == source_count_reg);
        end
    end

    // column memory
    logic [CW-1:0]             rd_cost;
    logic [cam_pkg::ROW_W-1:0] rd_row;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [CW-1:0]             wr_cost;
    logic [cam_pkg::ROW_W-1:0] wr_row;

    cam_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (in_accept),
        .rd_addr (in_col[AW-1:0]),
        .rd_cost (rd_cost),
        .rd_row  (rd_row),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_cost (wr_cost),
        .wr_row  (wr_row)
    );

    // compare and write back
    cam_pkg::cam_ctrl_t        upd_ctrl;
    logic                      upd_has;
    logic [cam_pkg::ROW_W-1:0] upd_src;

    always_comb begin
        upd_ctrl.commit    = s1_advance;
        upd_ctrl.first_row = s1_first_reg;
    end

    cam_update #(
        .AW (AW),
        .CW (CW)
    ) u_update (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (upd_ctrl),
        .addr         (s1_col_reg[AW-1:0]),
        .cost         (s1_cost_reg),
        .row          (s1_row_reg),
        .source_count (source_count_reg),
        .rd_cost      (rd_cost),
        .rd_row       (rd_row),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_cost      (wr_cost),
        .wr_row       (wr_row),
        .has_source   (upd_has),
        .source_index (upd_src)
    );

    // output register: loads on a reporting word, clears when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_advance && s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_advance && s1_last_reg) begin
            m_target_reg <= s1_col_reg;
            m_has_reg    <= upd_has;
            m_src_reg    <= upd_src;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_has_reg;
    assign m_tdata  = {{(cam_pkg::M_TDATA_W - cam_pkg::COL_W - cam_pkg::ROW_W){1'b0}},
                       m_src_reg, m_target_reg};

endmodule

>>> sv/cam_store.sv
// Column state memories: best cost and best row, registered read.
module cam_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int CW    = 32
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [CW-1:0]               rd_cost,
    output logic [cam_pkg::ROW_W-1:0]   rd_row,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [CW-1:0]               wr_cost,
    input  logic [cam_pkg::ROW_W-1:0]   wr_row
);

    logic [CW-1:0]             cost_mem [0:DEPTH-1];
    logic [cam_pkg::ROW_W-1:0] row_mem  [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cost_mem[wr_addr] <= wr_cost;
            row_mem[wr_addr]  <= wr_row;
        end
    end

    // read-before-write on a same-address collision; the update stage forwards
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_cost <= cost_mem[rd_addr];
            rd_row  <= row_mem[rd_addr];
        end
    end

endmodule

>>> sv/cam_update.sv
// Compare and update stage with write-back forwarding.
module cam_update #(
    parameter int AW = 8,
    parameter int CW = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cam_pkg::cam_ctrl_t              ctrl,
    input  logic [AW-1:0]                   addr,
    input  logic [CW-1:0]                   cost,
    input  logic [cam_pkg::ROW_W-1:0]       row,
    input  logic [cam_pkg::SRC_CNT_W-1:0]   source_count,
    input  logic [CW-1:0]                   rd_cost,
    input  logic [cam_pkg::ROW_W-1:0]       rd_row,
    output logic                            wr_en,
    output logic [AW-1:0]                   wr_addr,
    output logic [CW-1:0]                   wr_cost,
    output logic [cam_pkg::ROW_W-1:0]       wr_row,
    output logic                            has_source,
    output logic [cam_pkg::ROW_W-1:0]       source_index
);

    // last write-back; always the newest value for its address
    logic                      fwd_valid_reg;
    logic [AW-1:0]             fwd_addr_reg;
    logic [CW-1:0]             fwd_cost_reg;
    logic [cam_pkg::ROW_W-1:0] fwd_row_reg;

    logic                      fwd_hit;
    logic [CW-1:0]             cur_cost;
    logic [cam_pkg::ROW_W-1:0] cur_row;
    logic [CW-1:0]             new_cost;
    logic [cam_pkg::ROW_W-1:0] new_row;

    always_comb begin
        fwd_hit  = fwd_valid_reg && (fwd_addr_reg == addr);
        cur_cost = fwd_hit ? fwd_cost_reg : rd_cost;
        cur_row  = fwd_hit ? fwd_row_reg  : rd_row;

        if (ctrl.first_row) begin
            new_cost = cost;
            new_row  = '0;
        end else if (cost < cur_cost) begin
            new_cost = cost;
            new_row  = row;
        end else begin
            new_cost = cur_cost;
            new_row  = cur_row;
        end

        has_source   = (new_row != source_count);
        source_index = has_source ? new_row : '0;
    end

    assign wr_en   = ctrl.commit;
    assign wr_addr = addr;
    assign wr_cost = new_cost;
    assign wr_row  = new_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (ctrl.commit) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            fwd_addr_reg <= addr;
            fwd_cost_reg <= new_cost;
            fwd_row_reg  <= new_row;
        end
    end

endmodule
